// ===== design/largest_ones_square_finder_defines.svh =====
// Assertion macros for the largest ones square finder.
// No dependencies; taken in by the top level with `include.
`ifndef LARGEST_ONES_SQUARE_FINDER_DEFINES_SVH
`define LARGEST_ONES_SQUARE_FINDER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clock, off during reset.
`define LSF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsf: assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define LSF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsf: assertion failed");

`else

`define LSF_ASSERT_NOW(lbl, ante, cons)
`define LSF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/lsf_pkg.sv =====
// Shared widths and limits of the largest ones square finder.
// No dependencies; used by the channel interfaces and the top level.
package lsf_pkg;

   localparam int SIDE_W = 11;
   localparam int AREA_W = 21;
   localparam int ROW_W  = 11;

   localparam logic [ROW_W-1:0]  ROW_RESET = 11'd1024;
   localparam logic [SIDE_W-1:0] SIDE_MAX  = 11'd2047;
   localparam logic [AREA_W-1:0] AREA_MAX  = 21'd2097151;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

endpackage

// ===== design/lsf_if.sv =====
// Valid/ready channels of the largest ones square finder: cell words in, results out.
// Depends on lsf_pkg for the field widths.
interface lsf_req_if;
   logic valid;
   logic ready;
   logic cell_req;
   logic last;

   modport source (output valid, output cell_req, output last, input ready);
   modport sink   (input valid, input cell_req, input last, output ready);
endinterface

interface lsf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lsf_pkg::SIDE_W-1:0] best_side;
   logic [lsf_pkg::AREA_W-1:0] best_area;

   modport source (output valid, output best_side, output best_area, input ready);
   modport sink   (input valid, input best_side, input best_area, output ready);
endinterface

// ===== design/largest_ones_square_finder.sv =====
// Largest all-ones square in a binary image streamed in raster order.
// Depends on lsf_pkg, lsf_if.sv and largest_ones_square_finder_defines.svh.
//
// Usage:
//  - req_if carries one cell per word (cell_req, last). A word is taken when
//    valid and ready are both high. last marks the final cell of an image.
//  - rsp_if carries one word per image (best_side, best_area), sent after the
//    word marked last. Nothing is sent for other cells.
//  - csr_wr_en/csr_wr_data set the row width (1..MAX_COLS, 0 acts as 1, larger
//    values act as MAX_COLS). Write it only between images, with the block idle.
// Timing:
//  - One cell per cycle, back to back, while req_if.ready is high. The row of
//    sizes sits in a line buffer RAM with registered read, issued when a cell
//    is taken; read-modify-write ends the next cycle, bypassing an entry hit.
//  - rsp_if.valid rises once the last cell has passed stage 1, the squaring
//    stage and the write into the 4-entry result queue.
//  - If rsp_if stalls, results wait in the queue; req_if.ready drops once the
//    queued plus in-flight results would fill it.
// Reset: clears the image state and the queue, row width returns to 1024.
//  The line buffer needs no clearing: the first row ignores what it reads.
`include "largest_ones_square_finder_defines.svh"

module largest_ones_square_finder #(
   parameter int MAX_COLS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   lsf_req_if.sink                   req_if,
   lsf_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  logic [lsf_pkg::ROW_W-1:0] csr_wr_data
);

   localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CmpW = ((ColW + 1) > lsf_pkg::ROW_W) ? (ColW + 1) : lsf_pkg::ROW_W;
   localparam int SW   = lsf_pkg::SIDE_W;
   localparam int AW   = lsf_pkg::AREA_W;
   localparam int CW   = lsf_pkg::RSP_CNT_W;

   // ---------------- configuration ----------------
   logic [lsf_pkg::ROW_W-1:0] row_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= lsf_pkg::ROW_RESET;
      end else if (csr_wr_en) begin
         row_width_ff <= csr_wr_data;
      end
   end

   logic [CmpW-1:0] width_raw;
   logic [CmpW-1:0] width_eff;

   always_comb begin
      width_raw = CmpW'(row_width_ff);
      if (width_raw == '0) begin
         width_eff = CmpW'(1);
      end else if (width_raw > CmpW'(MAX_COLS)) begin
         width_eff = CmpW'(MAX_COLS);
      end else begin
         width_eff = width_raw;
      end
   end

   // ---------------- stage 0: accept, address, line buffer read ----------------
   logic            accept;
   logic [ColW-1:0] column_index_ff;
   logic [ColW-1:0] column_index_in;
   logic            first_row_ff;
   logic            first_row_in;
   logic [CmpW-1:0] col_plus;

   // stage 1 registers
   logic            s1_valid_ff;
   logic            s1_last_ff;
   logic            s1_cell_ff;
   logic            s1_first_ff;
   logic [ColW-1:0] s1_col_ff;
   logic            s1_fwd_ff;
   logic [SW-1:0]   s1_fwd_val_ff;
   logic [SW-1:0]   rd_data_ff;
   logic [SW-1:0]   s1_size;

   // stage 2 and queue
   logic            s2_valid_ff;
   logic [SW-1:0]   s2_side_ff;
   logic [CW-1:0]   q_count_ff;
   logic [CW-1:0]   in_flight;

   assign in_flight = CW'(s1_valid_ff & s1_last_ff) + CW'(s2_valid_ff) + q_count_ff;
   assign req_if.ready = (in_flight < CW'(lsf_pkg::RSP_DEPTH));
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      col_plus        = CmpW'(column_index_ff) + CmpW'(1);
      column_index_in = column_index_ff;
      first_row_in    = first_row_ff;
      if (accept) begin
         if (req_if.last) begin
            column_index_in = '0;
            first_row_in    = 1'b1;
         end else if (col_plus >= width_eff) begin
            column_index_in = '0;
            first_row_in    = 1'b0;
         end else begin
            column_index_in = col_plus[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff <= '0;
         first_row_ff    <= 1'b1;
         s1_valid_ff     <= 1'b0;
      end else begin
         column_index_ff <= column_index_in;
         first_row_ff    <= first_row_in;
         s1_valid_ff     <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff  <= req_if.last;
         s1_cell_ff  <= req_if.cell_req;
         s1_first_ff <= first_row_ff;
         s1_col_ff   <= column_index_ff;
         // stage 1 writes this same entry now: take its value instead of the RAM
         s1_fwd_ff     <= s1_valid_ff && (s1_col_ff == column_index_ff);
         s1_fwd_val_ff <= s1_size;
      end
   end

   // line buffer of sizes from the row above
   logic [SW-1:0] line_mem [MAX_COLS];

   always_ff @(posedge clock) begin
      rd_data_ff <= line_mem[column_index_ff];
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= s1_size;
      end
   end

   // ---------------- stage 1: size of the cell, running state ----------------
   logic [SW-1:0] left_size_ff;
   logic [SW-1:0] diag_size_ff;
   logic [SW-1:0] best_ff;
   logic [SW-1:0] up_size;
   logic [SW-1:0] min_ul;
   logic [SW-1:0] min_all;
   logic [SW:0]   grown;
   logic [SW-1:0] best_in;

   always_comb begin
      if (s1_first_ff) begin
         up_size = '0;
      end else if (s1_fwd_ff) begin
         up_size = s1_fwd_val_ff;
      end else begin
         up_size = rd_data_ff;
      end
      min_ul  = (up_size < left_size_ff) ? up_size : left_size_ff;
      min_all = (min_ul < diag_size_ff) ? min_ul : diag_size_ff;
      grown   = {1'b0, min_all} + {{SW{1'b0}}, 1'b1};
      if (!s1_cell_ff) begin
         s1_size = '0;
      end else if (s1_first_ff || (s1_col_ff == '0)) begin
         s1_size = SW'(1);
      end else if (grown[SW]) begin
         s1_size = lsf_pkg::SIDE_MAX;
      end else begin
         s1_size = grown[SW-1:0];
      end
      best_in = (s1_size > best_ff) ? s1_size : best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_size_ff <= '0;
         diag_size_ff <= '0;
         best_ff      <= '0;
         s2_valid_ff  <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_last_ff;
         if (s1_valid_ff) begin
            if (s1_last_ff) begin
               left_size_ff <= '0;
               diag_size_ff <= '0;
               best_ff      <= '0;
            end else begin
               left_size_ff <= s1_size;
               diag_size_ff <= up_size;
               best_ff      <= best_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_last_ff) begin
         s2_side_ff <= best_in;
      end
   end

   // ---------------- stage 2: square, result queue ----------------
   logic [2*SW-1:0] square;
   logic [AW-1:0]   area_sat;

   assign square   = s2_side_ff * s2_side_ff;
   assign area_sat = (square > (2*SW)'(lsf_pkg::AREA_MAX)) ? lsf_pkg::AREA_MAX
                                                          : square[AW-1:0];

   logic [SW-1:0]                   q_side_ff [lsf_pkg::RSP_DEPTH];
   logic [AW-1:0]                   q_area_ff [lsf_pkg::RSP_DEPTH];
   logic [lsf_pkg::RSP_PTR_W-1:0]   q_wr_ptr_ff;
   logic [lsf_pkg::RSP_PTR_W-1:0]   q_rd_ptr_ff;
   logic                            q_pop;

   assign q_pop = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         if (s2_valid_ff) begin
            q_wr_ptr_ff <= q_wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            q_rd_ptr_ff <= q_rd_ptr_ff + 1'b1;
         end
         q_count_ff <= q_count_ff + CW'(s2_valid_ff) - CW'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         q_side_ff[q_wr_ptr_ff] <= s2_side_ff;
         q_area_ff[q_wr_ptr_ff] <= area_sat;
      end
   end

   assign rsp_if.valid     = (q_count_ff != '0);
   assign rsp_if.best_side = q_side_ff[q_rd_ptr_ff];
   assign rsp_if.best_area = q_area_ff[q_rd_ptr_ff];

   // ---------------- checks ----------------
   `LSF_ASSERT_NOW(a_queue_bound, 1'b1, in_flight <= CW'(lsf_pkg::RSP_DEPTH))
   `LSF_ASSERT_NEXT(a_last_reaches_s1, accept && req_if.last, s1_valid_ff && s1_last_ff)
   `LSF_ASSERT_NEXT(a_col_steps, accept,
      (column_index_ff == '0) || (column_index_ff == $past(column_index_ff) + 1'b1))
   `LSF_ASSERT_NOW(a_area_matches_side, rsp_if.valid,
      (rsp_if.best_area == '0) == (rsp_if.best_side == '0))

endmodule
